>>> rtl/lstat_pkg.sv
`timescale 1ns / 1ps

package lstat_pkg;

    localparam logic [1:0]  MODE_RECORD     = 2'd0;
    localparam logic [1:0]  MODE_QUERY      = 2'd1;
    localparam logic [1:0]  MODE_CLEAR      = 2'd2;

    localparam logic [16:0] ALPHA_ONE       = 17'd65536;
    localparam logic [16:0] ALPHA_RESET     = 17'd6554;
    localparam logic [63:0] ROUND_HALF      = 64'd32768;
    localparam logic [31:0] BURST_MIN_CALLS = 32'd3;
    localparam logic [31:0] CALLS_MAX       = 32'hFFFF_FFFF;
    localparam logic [31:0] RECORDS_MAX     = 32'hFFFF_FFFF;
    localparam logic [47:0] TOTAL_MAX       = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] calls;
        logic [47:0] total;
        logic [31:0] max;
        logic [31:0] min;
        logic [31:0] last;
        logic [47:0] ema;
    } entry_t;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       clr_all;
        logic [4:0] idx;
    } tbl_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EM0,
        ST_EM1,
        ST_EM2,
        ST_EM3,
        ST_WRITE,
        ST_BM0,
        ST_BM1,
        ST_BM2,
        ST_BSUB,
        ST_DONE
    } state_t;

endpackage

>>> rtl/lstat_table.sv
`timescale 1ns / 1ps

module lstat_table
    import lstat_pkg::*;
#(
    parameter int DEPTH = 20,
    parameter int IDX_W = 5
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    input  entry_t   wr_data,
    output entry_t   rd_data,
    output logic     rd_valid
);

    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic               rd_valid_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic [IDX_W-1:0]   idx;

    assign idx = req.idx[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[idx] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[idx];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clr_all)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[idx];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

>>> rtl/per_phase_latency_statistics_core.sv
`timescale 1ns / 1ps
// Per-phase latency statistics table.
// Input channel (in_valid / in_stall) carries one beat per item: mode, phase_index
// and sample_us. A record beat folds a sample into the phase entry, a query beat
// reads it back, a clear beat empties every entry and zeroes the record count.
// Output channel (out_valid / out_stall) returns exactly one beat per item.
// ema_alpha is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while the block is idle, which the block does not enforce. One item is in flight at
// a time; the entry table is a synchronous RAM and the moving average and burst test
// share one 32x32 multiplier, one product a cycle. A record runs LOAD, EM0-EM3, WRITE,
// BM0-BM2 and BSUB; a query skips EM0-EM3 and WRITE; clear and invalid go to DONE.
// The next beat is taken in the cycle after the result enters the output register.
// A finished result waits in the output register while out_stall is high; the
// next item is taken meanwhile and holds in its last step until the register frees.
// Reset empties every entry, zeroes the record count and loads ema_alpha 6554.

module per_phase_latency_statistics_core
    import lstat_pkg::*;
#(
    parameter int NUM_PHASES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [4:0]  phase_index,
    input  logic [31:0] sample_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        phase_ok,
    output logic [31:0] call_count,
    output logic [47:0] total_us,
    output logic [31:0] max_us,
    output logic [31:0] min_us,
    output logic [31:0] last_us,
    output logic [47:0] ema_us,
    output logic        bursty,
    output logic [31:0] records_total
);

    localparam int IDX_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

    state_t       state_reg, state_next;
    entry_t       work_reg, work_next;
    entry_t       base;
    entry_t       tbl_rd_data;
    entry_t       tbl_wr_data;
    tbl_req_t     tbl_req;
    logic         tbl_rd_valid;

    logic [63:0]  acc_reg, acc_next;
    logic [63:0]  prod_reg, prod_next;
    logic [79:0]  pf_reg, pf_next;
    logic [79:0]  diff_reg, diff_next;
    logic [79:0]  t_wide;
    logic [31:0]  mul_a, mul_b;

    logic [1:0]   mode_reg, mode_next;
    logic [31:0]  sample_reg, sample_next;
    logic [4:0]   phase_reg, phase_next;
    logic         res_ok_reg, res_ok_next;
    logic         burst_chk_reg, burst_chk_next;
    logic [31:0]  count_reg, count_next;
    logic [16:0]  alpha_reg;
    logic [16:0]  alpha_eff, alpha_inv;

    logic         in_accept;
    logic         in_range;
    logic         out_load;
    logic         burst_now;
    logic [48:0]  total_sum;

    logic         out_valid_reg, out_valid_next;
    logic         out_ok_reg;
    entry_t       out_entry_reg;
    logic         out_burst_reg;
    logic [31:0]  out_records_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign in_range  = ({1'b0, phase_index} < 6'(NUM_PHASES));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_inv = ALPHA_ONE - alpha_eff;
    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    assign t_wide    = {16'd0, work_reg.total, 16'd0};

    assign burst_now = burst_chk_reg
                    && (work_reg.calls >= BURST_MIN_CALLS)
                    && (work_reg.total != 48'd0)
                    && ({diff_reg, 1'b0} > {1'b0, t_wide});

    lstat_table #(
        .DEPTH (NUM_PHASES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .wr_data  (tbl_wr_data),
        .rd_data  (tbl_rd_data),
        .rd_valid (tbl_rd_valid)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((mode inside {MODE_RECORD, MODE_QUERY}) && in_range)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD:  state_next = (mode_reg == MODE_RECORD) ? ST_EM0 : ST_BM0;
            ST_EM0:   state_next = ST_EM1;
            ST_EM1:   state_next = ST_EM2;
            ST_EM2:   state_next = ST_EM3;
            ST_EM3:   state_next = ST_WRITE;
            ST_WRITE: state_next = ST_BM0;
            ST_BM0:   state_next = ST_BM1;
            ST_BM1:   state_next = ST_BM2;
            ST_BM2:   state_next = ST_BSUB;
            ST_BSUB:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        work_next      = work_reg;
        acc_next       = acc_reg;
        pf_next        = pf_reg;
        diff_next      = diff_reg;
        mode_next      = mode_reg;
        sample_next    = sample_reg;
        phase_next     = phase_reg;
        res_ok_next    = res_ok_reg;
        burst_chk_next = burst_chk_reg;
        count_next     = count_reg;
        mul_a          = 32'd0;
        mul_b          = 32'd0;
        base           = '0;
        total_sum      = '0;

        tbl_req.rd_en   = 1'b0;
        tbl_req.wr_en   = 1'b0;
        tbl_req.clr_all = 1'b0;
        tbl_req.idx     = in_accept ? phase_index : phase_reg;
        tbl_wr_data     = work_reg;
        tbl_wr_data.ema = acc_reg[63:16];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next      = mode;
                    sample_next    = sample_us;
                    phase_next     = phase_index;
                    work_next      = '0;
                    burst_chk_next = 1'b0;
                    if (mode == MODE_CLEAR)
                    begin
                        tbl_req.clr_all = 1'b1;
                        count_next      = 32'd0;
                        res_ok_next     = 1'b1;
                    end
                    else if ((mode inside {MODE_RECORD, MODE_QUERY}) && in_range)
                    begin
                        tbl_req.rd_en  = 1'b1;
                        res_ok_next    = 1'b1;
                        burst_chk_next = 1'b1;
                    end
                    else
                    begin
                        res_ok_next = 1'b0;
                    end
                end
            end
            ST_LOAD:
            begin
                if (tbl_rd_valid)
                begin
                    base = tbl_rd_data;
                end
                else if (mode_reg == MODE_RECORD)
                begin
                    base.max = sample_reg;
                    base.min = sample_reg;
                end
                work_next = base;
                acc_next  = ROUND_HALF;
                if (mode_reg == MODE_RECORD)
                begin
                    total_sum       = {1'b0, base.total} + {17'd0, sample_reg};
                    work_next.calls = (base.calls == CALLS_MAX) ? base.calls
                                                               : base.calls + 32'd1;
                    work_next.total = total_sum[48] ? TOTAL_MAX : total_sum[47:0];
                    work_next.max   = (sample_reg > base.max) ? sample_reg : base.max;
                    work_next.min   = (sample_reg < base.min) ? sample_reg : base.min;
                    work_next.last  = sample_reg;
                    count_next      = (count_reg == RECORDS_MAX) ? count_reg
                                                                 : count_reg + 32'd1;
                end
            end
            ST_EM0:
            begin
                mul_a = {15'd0, alpha_eff};
                mul_b = sample_reg;
            end
            ST_EM1:
            begin
                mul_a    = {15'd0, alpha_inv};
                mul_b    = {8'd0, work_reg.ema[23:0]};
                acc_next = acc_reg + {prod_reg[47:0], 16'd0};
            end
            ST_EM2:
            begin
                mul_a    = {15'd0, alpha_inv};
                mul_b    = {8'd0, work_reg.ema[47:24]};
                acc_next = acc_reg + prod_reg;
            end
            ST_EM3:
            begin
                acc_next = acc_reg + {prod_reg[39:0], 24'd0};
            end
            ST_WRITE:
            begin
                tbl_req.wr_en = 1'b1;
                work_next.ema = acc_reg[63:16];
            end
            ST_BM0:
            begin
                mul_a = {8'd0, work_reg.ema[23:0]};
                mul_b = work_reg.calls;
            end
            ST_BM1:
            begin
                mul_a   = {8'd0, work_reg.ema[47:24]};
                mul_b   = work_reg.calls;
                pf_next = {16'd0, prod_reg};
            end
            ST_BM2:
            begin
                pf_next = pf_reg + {prod_reg[55:0], 24'd0};
            end
            ST_BSUB:
            begin
                diff_next = (pf_reg >= t_wide) ? (pf_reg - t_wide) : (t_wide - pf_reg);
            end
            ST_DONE:
            begin
                work_next = work_reg;
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 32'd0;
            alpha_reg     <= ALPHA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                alpha_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        pf_reg        <= pf_next;
        diff_reg      <= diff_next;
        mode_reg      <= mode_next;
        sample_reg    <= sample_next;
        phase_reg     <= phase_next;
        res_ok_reg    <= res_ok_next;
        burst_chk_reg <= burst_chk_next;
        if (out_load)
        begin
            out_ok_reg      <= res_ok_reg;
            out_entry_reg   <= work_reg;
            out_burst_reg   <= burst_now;
            out_records_reg <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase_ok      = out_ok_reg;
    assign call_count    = out_entry_reg.calls;
    assign total_us      = out_entry_reg.total;
    assign max_us        = out_entry_reg.max;
    assign min_us        = out_entry_reg.min;
    assign last_us       = out_entry_reg.last;
    assign ema_us        = out_entry_reg.ema;
    assign bursty        = out_burst_reg;
    assign records_total = out_records_reg;

endmodule

>>> rtl/lstat_checker.sv
`timescale 1ns / 1ps

module lstat_checker
    import lstat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_wr_en,
    input logic [16:0] cfg_wr_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  mode,
    input logic [4:0]  phase_index,
    input logic [31:0] sample_us,
    input logic        out_valid,
    input logic        out_stall,
    input logic        phase_ok,
    input logic [31:0] call_count,
    input logic [47:0] total_us,
    input logic [31:0] max_us,
    input logic [31:0] min_us,
    input logic [31:0] last_us,
    input logic [47:0] ema_us,
    input logic        bursty,
    input logic [31:0] records_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(call_count)
            && $stable(total_us) && $stable(ema_us) && $stable(records_total))
        else $error("stalled output beat changed");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while an item is in flight");

    a_bad_phase_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !phase_ok |-> call_count == 32'd0 && total_us == 48'd0
            && ema_us == 48'd0 && !bursty)
        else $error("ignored item returned statistics");

    a_burst_calls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bursty |-> call_count >= BURST_MIN_CALLS && total_us != 48'd0)
        else $error("bursty flagged with too few calls");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && call_count != 32'd0 |-> min_us <= last_us && last_us <= max_us)
        else $error("last sample outside min and max");

endmodule

bind per_phase_latency_statistics_core lstat_checker u_lstat_checker (.*);

>>> tb/sv/tb_per_phase_latency_statistics_core.sv
`timescale 1ns / 1ps

module tb_per_phase_latency_statistics_core;
    import lstat_pkg::*;

    localparam int         NUM_PHASES = 20;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         IDLE_PAD   = 16;
    localparam int         HOLD_LEN   = 300;
    localparam int         PHASE_LEN  = 220;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  phase;
        logic [31:0] sample;
    } stat_req_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] calls;
        logic [47:0] total;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] last;
        logic [47:0] ema;
        logic        bursty;
        logic [31:0] records;
    } stats_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [16:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = '0;
    logic [4:0]  phase_index = '0;
    logic [31:0] sample_us = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        phase_ok;
    logic [31:0] call_count;
    logic [47:0] total_us;
    logic [31:0] max_us;
    logic [31:0] min_us;
    logic [31:0] last_us;
    logic [47:0] ema_us;
    logic        bursty;
    logic [31:0] records_total;

    stat_req_t   beat_q[$];
    stats_res_t  stats_due_q[$];

    entry_t      tbl[32];
    logic [31:0] live = '0;
    logic [31:0] rec_count = '0;
    logic [16:0] alpha_now = ALPHA_RESET;

    logic        in_took = 1'b0;
    bit          calm = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    int          err_cnt = 0;
    int          n_taken = 0;
    int          n_rec = 0;
    int          n_query = 0;
    int          n_clear = 0;
    int          n_spare = 0;
    int          n_checked = 0;
    int          n_bursty = 0;
    int          n_alpha = 1;

    per_phase_latency_statistics_core #(
        .NUM_PHASES (NUM_PHASES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .phase_index   (phase_index),
        .sample_us     (sample_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .phase_ok      (phase_ok),
        .call_count    (call_count),
        .total_us      (total_us),
        .max_us        (max_us),
        .min_us        (min_us),
        .last_us       (last_us),
        .ema_us        (ema_us),
        .bursty        (bursty),
        .records_total (records_total)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic stats_res_t predict_stats(stat_req_t rq);
        stats_res_t  r;
        entry_t      e;
        logic [16:0] a;
        logic [16:0] na;
        logic [65:0] acc;
        logic [81:0] prod;
        logic [81:0] tsh;
        logic [81:0] diff;
        r = '0;
        if (rq.mode == MODE_CLEAR)
        begin
            live = '0;
            rec_count = '0;
            r.ok = 1'b1;
            return r;
        end
        if (rq.mode == MODE_SPARE || rq.phase >= NUM_PHASES)
        begin
            r.records = rec_count;
            return r;
        end
        if (rq.mode == MODE_RECORD)
        begin
            e = tbl[rq.phase];
            if (!live[rq.phase])
            begin
                e = '0;
                e.max = rq.sample;
                e.min = rq.sample;
            end
            a = (alpha_now > ALPHA_ONE) ? ALPHA_ONE : alpha_now;
            na = ALPHA_ONE - a;
            if (e.calls != CALLS_MAX)
                e.calls = e.calls + 32'd1;
            if (TOTAL_MAX - e.total < 48'(rq.sample))
                e.total = TOTAL_MAX;
            else
                e.total = e.total + 48'(rq.sample);
            if (rq.sample > e.max)
                e.max = rq.sample;
            if (rq.sample < e.min)
                e.min = rq.sample;
            e.last = rq.sample;
            acc = 66'(a) * (66'(rq.sample) << 16) + 66'(na) * 66'(e.ema) + 66'(ROUND_HALF);
            e.ema = acc[63:16];
            tbl[rq.phase] = e;
            live[rq.phase] = 1'b1;
            if (rec_count != RECORDS_MAX)
                rec_count = rec_count + 32'd1;
        end
        r.ok = 1'b1;
        if (live[rq.phase])
        begin
            e = tbl[rq.phase];
            r.calls = e.calls;
            r.total = e.total;
            r.hi = e.max;
            r.lo = e.min;
            r.last = e.last;
            r.ema = e.ema;
            prod = 82'(e.calls) * 82'(e.ema);
            tsh = 82'(e.total) << 16;
            diff = (prod >= tsh) ? prod - tsh : tsh - prod;
            r.bursty = (e.calls >= BURST_MIN_CALLS) && (e.total != '0) && ((diff << 1) > tsh);
        end
        r.records = rec_count;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_sample(logic [4:0] p);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 32'd0;
        if (r < 10)
            return 32'hFFFF_FFFF;
        if (r < 20)
            return $urandom;
        if (r < 30)
            return $urandom_range(0, 1000);
        return 32'(p) * 32'd4000 + 32'd500 + $urandom_range(0, 50);
    endfunction

    task automatic push_item(logic [1:0] m, logic [4:0] p, logic [31:0] s);
        stat_req_t rq;
        rq.mode = m;
        rq.phase = p;
        rq.sample = s;
        beat_q = {beat_q, rq};
    endtask

    task automatic push_random();
        int          r;
        logic [1:0]  m;
        logic [4:0]  p;
        r = $urandom_range(0, 99);
        if (r < 62)
            m = MODE_RECORD;
        else if (r < 90)
            m = MODE_QUERY;
        else if (r < 92)
            m = MODE_CLEAR;
        else if (r < 95)
            m = MODE_SPARE;
        else
            m = MODE_RECORD;
        r = $urandom_range(0, 99);
        if (r < 10)
            p = 5'($urandom_range(20, 31));
        else if (r < 60)
            p = 5'($urandom_range(0, 3));
        else
            p = 5'($urandom_range(0, NUM_PHASES - 1));
        push_item(m, p, pick_sample(p));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (beat_q.size() != 0 || in_valid || stats_due_q.size() != 0);
        repeat (IDLE_PAD) @(negedge clk);
    endtask

    task automatic write_alpha(logic [16:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        alpha_now = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        n_alpha++;
    endtask

    // drive one beat at a time from the pending queue
    always @(negedge clk)
    begin
        stat_req_t nxt;
        if (!in_valid || in_took)
        begin
            if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (beat_q.size() != 0)
            begin
                nxt = beat_q.pop_front();
                mode <= nxt.mode;
                phase_index <= nxt.phase;
                sample_us <= nxt.sample;
                in_valid <= 1'b1;
                gap_left <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && n_taken >= 400 + holds_done * 800)
        begin
            hold_left <= HOLD_LEN;
            holds_done <= holds_done + 1;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 2) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        stat_req_t  rq;
        stats_res_t want;
        stats_res_t seen;
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                rq.mode = mode;
                rq.phase = phase_index;
                rq.sample = sample_us;
                stats_due_q = {stats_due_q, predict_stats(rq)};
                n_taken++;
                case (mode)
                    MODE_RECORD: n_rec++;
                    MODE_QUERY:  n_query++;
                    MODE_CLEAR:  n_clear++;
                    default:     n_spare++;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen.ok = phase_ok;
                seen.calls = call_count;
                seen.total = total_us;
                seen.hi = max_us;
                seen.lo = min_us;
                seen.last = last_us;
                seen.ema = ema_us;
                seen.bursty = bursty;
                seen.records = records_total;
                if (stats_due_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("ERROR %0t: result beat with nothing outstanding", $realtime);
                    err_cnt++;
                end
                else
                begin
                    want = stats_due_q.pop_front();
                    n_checked++;
                    if (want.bursty)
                        n_bursty++;
                    if (seen !== want)
                    begin
                        if (err_cnt < 10)
                        begin
                            $display("ERROR %0t: exp ok=%b calls=%h total=%h max=%h min=%h",
                                     $realtime, want.ok, want.calls, want.total, want.hi, want.lo);
                            $display("    last=%h ema=%h bursty=%b records=%h",
                                     want.last, want.ema, want.bursty, want.records);
                            $display("    got ok=%b calls=%h total=%h max=%h min=%h",
                                     seen.ok, seen.calls, seen.total, seen.hi, seen.lo);
                            $display("    last=%h ema=%h bursty=%b records=%h",
                                     seen.last, seen.ema, seen.bursty, seen.records);
                        end
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [16:0] alphas[7];
        alphas[0] = 17'd0;
        alphas[1] = ALPHA_ONE;
        alphas[2] = 17'h1FFFF;
        alphas[3] = 17'd1;
        alphas[4] = 17'd32768;
        alphas[5] = 17'($urandom_range(0, 131071));
        alphas[6] = ALPHA_RESET;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        push_item(MODE_QUERY, 5'd0, 32'd0);
        push_item(MODE_RECORD, 5'd0, 32'd0);
        push_item(MODE_RECORD, 5'd0, 32'hFFFF_FFFF);
        push_item(MODE_RECORD, 5'd0, 32'd5);
        push_item(MODE_QUERY, 5'd0, 32'hFFFF_FFFF);
        push_item(MODE_RECORD, 5'd19, 32'd1000);
        push_item(MODE_RECORD, 5'd19, 32'd1000);
        push_item(MODE_RECORD, 5'd19, 32'd1000);
        push_item(MODE_QUERY, 5'd19, 32'd0);
        push_item(MODE_RECORD, 5'd20, 32'd1234);
        push_item(MODE_QUERY, 5'd31, 32'd0);
        push_item(MODE_SPARE, 5'd0, 32'd0);
        push_item(MODE_SPARE, 5'd31, 32'hFFFF_FFFF);
        push_item(MODE_RECORD, 5'd31, 32'hFFFF_FFFF);
        push_item(MODE_CLEAR, 5'd0, 32'd0);
        push_item(MODE_QUERY, 5'd0, 32'd0);
        push_item(MODE_QUERY, 5'd19, 32'd0);
        push_item(MODE_RECORD, 5'd19, 32'd77);
        push_item(MODE_CLEAR, 5'd31, 32'hFFFF_FFFF);
        push_item(MODE_RECORD, 5'd10, 32'h8000_0000);

        for (int k = 0; k < 7; k++)
        begin
            write_alpha(alphas[k]);
            calm = (k == 1 || k == 4);
            for (int i = 0; i < PHASE_LEN; i++)
                push_random();
        end

        wait_idle();
        $display("Ran %0d items: %0d records, %0d queries, %0d clears, %0d unused-mode",
                 n_taken, n_rec, n_query, n_clear, n_spare);
        $display("Checked %0d results (%0d bursty) across %0d alpha settings, %0d errors",
                 n_checked, n_bursty, n_alpha, err_cnt);
        if (err_cnt == 0 && stats_due_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> per_phase_latency_statistics_core.f
rtl/lstat_pkg.sv
rtl/lstat_table.sv
rtl/per_phase_latency_statistics_core.sv
rtl/lstat_checker.sv
tb/sv/tb_per_phase_latency_statistics_core.sv
